/* rtl/kmsd_pkg.sv */
// Shared types, sizes and grid helpers for the keyboard matrix scanner.
// No dependencies; used by kmsd_limit and the scanner top module.
package kmsd_pkg;

    localparam int NUM_STATES = 8;
    localparam int NUM_LINES  = 7;
    localparam int NUM_ROWS   = 4;
    localparam int NUM_COLS   = 14;
    localparam int NUM_KEYS   = NUM_STATES * NUM_LINES;

    localparam int ST_W    = 3;
    localparam int KEY_W   = 6;
    localparam int COL_W   = 4;
    localparam int ROW_W   = 2;
    localparam int FRAME_W = 56;
    localparam int TIME_W  = 32;
    localparam int WIN_W   = 16;
    localparam int LIM_W   = 6;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 1'b1;

    localparam logic [WIN_W-1:0] WIN_RESET   = WIN_W'(30);
    localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(24);

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             shift;
        logic             ctrl;
        logic             alt;
        logic             last;
    } t_evt;

    // Frame bit of a grid cell: drive state is (3 - row), plus 4 for even
    // columns; sense line is col / 2.
    function automatic logic [KEY_W-1:0] key_bit(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
        logic [ST_W-1:0] s;
        s = {~col[0], ROW_W'(3) - row};
        return {s, 3'b000} - {3'b000, s} + {3'b000, col[COL_W-1:1]};
    endfunction

    // fn, shift (row 2) and ctrl, opt, alt (row 3) by grid index
    function automatic logic is_modifier(input logic [KEY_W-1:0] key);
        return (key == KEY_W'(2 * NUM_COLS))     || (key == KEY_W'(2 * NUM_COLS + 1)) ||
               (key == KEY_W'(3 * NUM_COLS))     || (key == KEY_W'(3 * NUM_COLS + 1)) ||
               (key == KEY_W'(3 * NUM_COLS + 2));
    endfunction

    localparam logic [KEY_W-1:0] SHIFT_BIT = key_bit(ROW_W'(2), COL_W'(1));
    localparam logic [KEY_W-1:0] CTRL_BIT  = key_bit(ROW_W'(3), COL_W'(0));
    localparam logic [KEY_W-1:0] ALT_BIT   = key_bit(ROW_W'(3), COL_W'(2));

endpackage

/* rtl/kmsd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kmsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/kmsd_limit.sv */
// Press-limit pass: walks the frame one drive state (7 sense bits) per cycle,
// keeps the first N set bits and finds new presses. Depends on kmsd_pkg.
module kmsd_limit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [kmsd_pkg::FRAME_W-1:0]  i_frame,
    input  logic [kmsd_pkg::LIM_W-1:0]    i_limit,
    output logic                          o_done,
    output logic [kmsd_pkg::FRAME_W-1:0]  o_kept,
    output logic [kmsd_pkg::FRAME_W-1:0]  o_cand
);
    import kmsd_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [ST_W-1:0]      r_st;
    logic [LIM_W-1:0]     r_taken;
    logic [FRAME_W-1:0]   r_frame;
    logic [FRAME_W-1:0]   r_kept;
    logic [FRAME_W-1:0]   r_was;
    logic [FRAME_W-1:0]   r_cand;

    logic [KEY_W-1:0]     base;
    logic [NUM_LINES-1:0] slice;
    logic [NUM_LINES-1:0] keep;
    logic [LIM_W-1:0]     cnt;

    assign base  = {r_st, 3'b000} - {3'b000, r_st};
    assign slice = r_frame[base +: NUM_LINES];

    // running count over one drive state; cnt never passes the limit
    always_comb begin
        cnt = r_taken;
        for (int j = 0; j < NUM_LINES; j++) begin
            keep[j] = 1'b0;
            if (slice[j] && (cnt < i_limit)) begin
                keep[j] = 1'b1;
                cnt     = cnt + LIM_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_st    <= '0;
            r_taken <= '0;
            r_was   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_frame <= i_frame;
                r_busy  <= 1'b1;
                r_st    <= '0;
                r_taken <= '0;
            end else if (r_busy) begin
                r_kept[base +: NUM_LINES] <= keep;
                r_cand[base +: NUM_LINES] <= keep & ~r_was[base +: NUM_LINES];
                r_was[base +: NUM_LINES]  <= keep;
                r_taken <= cnt;
                r_st    <= r_st + ST_W'(1);
                if (r_st == ST_W'(NUM_STATES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_kept = r_kept;
    assign o_cand = r_cand;

endmodule

/* rtl/keyboard_matrix_scan_debounce.sv */
// Keyboard matrix scanner top: config registers, key-walk sequencer, debounce.
// Depends on kmsd_pkg, kmsd_limit and kmsd_ram.
// One input beat is a full 56-bit scan frame plus a ms time stamp. The block
// takes a frame, runs the press-limit pass (one drive state per cycle, then a
// done strobe), then walks the 56 keys in row-major order. A newly pressed key
// passes from the read state to an event state, since each such key reads its
// last-emit time from a 56x32 RAM with registered read; it may wait there while
// the output side stalls. A frame is taken only after the previous one has
// closed; o_ready is high only between frames. Each reported key is held back
// one event so the final event of a frame carries last_event; the final beat
// is loaded in the closing flush state, which waits while the output is full.
// Emit times read as zero until first written.
module keyboard_matrix_scan_debounce (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [kmsd_pkg::FRAME_W-1:0]      i_sense_frame,
    input  logic [kmsd_pkg::TIME_W-1:0]       i_time_stamp,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [kmsd_pkg::COL_W-1:0]        o_key_column,
    output logic [kmsd_pkg::ROW_W-1:0]        o_key_row,
    output logic                              o_shift_held,
    output logic                              o_ctrl_held,
    output logic                              o_alt_held,
    output logic                              o_last_event,
    input  logic                              i_cfg_we,
    input  logic [kmsd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [kmsd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import kmsd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_KEY_RD,
        ST_KEY_EV,
        ST_FLUSH
    } t_state;

    t_state               r_state;
    logic [WIN_W-1:0]     r_win;
    logic [LIM_W-1:0]     r_limit;
    logic [TIME_W-1:0]    r_now;
    logic [KEY_W-1:0]     r_key;
    logic [ROW_W-1:0]     r_row;
    logic [COL_W-1:0]     r_col;
    logic [NUM_KEYS-1:0]  r_tvalid;
    t_evt                 r_out;
    logic                 r_out_valid;
    t_evt                 r_pend;
    logic                 r_pend_valid;

    logic                 lim_start;
    logic                 lim_done;
    logic [FRAME_W-1:0]   lim_kept;
    logic [FRAME_W-1:0]   lim_cand;

    logic [TIME_W-1:0]    ram_rdata;
    logic                 ram_we;

    logic [KEY_W-1:0]     cur_bit;
    logic                 cand;
    logic [TIME_W-1:0]    emit_t;
    logic [TIME_W-1:0]    since;
    logic                 held;
    logic                 mod_key;
    logic                 out_free;
    logic                 out_load;
    logic                 adv;
    logic                 last_key;
    t_evt                 new_evt;

    assign lim_start = i_valid && o_ready;

    kmsd_limit u_limit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lim_start),
        .i_frame (i_sense_frame),
        .i_limit (r_limit),
        .o_done  (lim_done),
        .o_kept  (lim_kept),
        .o_cand  (lim_cand)
    );

    kmsd_ram #(
        .WIDTH (TIME_W),
        .DEPTH (NUM_KEYS)
    ) u_emit_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_key),
        .i_wdata (r_now),
        .i_raddr (r_key),
        .o_rdata (ram_rdata)
    );

    assign cur_bit  = key_bit(r_row, r_col);
    assign cand     = lim_cand[cur_bit];
    assign emit_t   = r_tvalid[r_key] ? ram_rdata : '0;
    assign since    = r_now - emit_t;
    assign held     = (r_win != '0) && (since < {{(TIME_W - WIN_W){1'b0}}, r_win});
    assign mod_key  = is_modifier(r_key);
    assign out_free = !r_out_valid || i_ready;
    assign last_key = (r_key == KEY_W'(NUM_KEYS - 1));

    // a reported key waits only when both the held-back event and the output are full
    assign ram_we = (r_state == ST_KEY_EV) && !held && (mod_key || !r_pend_valid || out_free);
    assign adv    = ((r_state == ST_KEY_RD) && !cand) ||
                    ((r_state == ST_KEY_EV) && (held || ram_we));

    // output register takes the held-back event
    assign out_load = ((r_state == ST_KEY_EV) && ram_we && !mod_key && r_pend_valid) ||
                      ((r_state == ST_FLUSH) && r_pend_valid && out_free);

    always_comb begin
        new_evt.col   = r_col;
        new_evt.row   = r_row;
        new_evt.shift = lim_kept[SHIFT_BIT];
        new_evt.ctrl  = lim_kept[CTRL_BIT];
        new_evt.alt   = lim_kept[ALT_BIT];
        new_evt.last  = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_win        <= WIN_RESET;
            r_limit      <= LIMIT_RESET;
            r_tvalid     <= '0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_key        <= '0;
            r_row        <= '0;
            r_col        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_DEBOUNCE: r_win   <= i_cfg_data[WIN_W-1:0];
                    REG_LIMIT:    r_limit <= i_cfg_data[LIM_W-1:0];
                    default:      ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (lim_start) begin
                        r_now   <= i_time_stamp;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (lim_done) begin
                        r_key   <= '0;
                        r_row   <= '0;
                        r_col   <= '0;
                        r_state <= ST_KEY_RD;
                    end
                end
                ST_KEY_RD: begin
                    if (cand) begin
                        r_state <= ST_KEY_EV;
                    end
                end
                ST_KEY_EV: begin
                    if (ram_we) begin
                        r_tvalid[r_key] <= 1'b1;
                        if (!mod_key) begin
                            if (r_pend_valid) begin
                                r_out <= r_pend;
                            end
                            r_pend       <= new_evt;
                            r_pend_valid <= 1'b1;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (!r_pend_valid) begin
                        r_state <= ST_IDLE;
                    end else if (out_free) begin
                        r_out        <= {r_pend.col, r_pend.row, r_pend.shift,
                                         r_pend.ctrl, r_pend.alt, 1'b1};
                        r_pend_valid <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            if (adv) begin
                r_state <= last_key ? ST_FLUSH : ST_KEY_RD;
                r_key   <= r_key + KEY_W'(1);
                if (r_col == COL_W'(NUM_COLS - 1)) begin
                    r_col <= '0;
                    r_row <= r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
        end
    end

    assign o_ready      = (r_state == ST_IDLE);
    assign o_valid      = r_out_valid;
    assign o_key_column = r_out.col;
    assign o_key_row    = r_out.row;
    assign o_shift_held = r_out.shift;
    assign o_ctrl_held  = r_out.ctrl;
    assign o_alt_held   = r_out.alt;
    assign o_last_event = r_out.last;

    // no held-back event may survive the end of a frame
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_valid)
        else $error("held-back event left over at frame end");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == ST_SCAN))
        else $error("accepted frame did not start the limit pass");

    a_limit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lim_done |-> (r_state == ST_SCAN))
        else $error("limit pass finished outside the scan phase");

    // the write may come after output stalls spent in the event state
    a_emit_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (($past(r_state) == ST_KEY_RD || $past(r_state) == ST_KEY_EV) &&
                    cand && r_key < KEY_W'(NUM_KEYS)))
        else $error("emit time written for a key that was not a new press");

endmodule
